>>> rtl/cpds_pkg.sv
// cpds_pkg: shared types and constants for the cluster partial dissimilarity sums block
// no dependencies

package cpds_pkg;

   // input item kinds
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_ENTRY = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;
   localparam logic [1:0] KIND_CLEAR = 2'd3;

   // result kinds
   localparam logic RES_ROW_SUM = 1'b0;
   localparam logic RES_READ    = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_NUM_ITEMS    = 2'd0;
   localparam logic [1:0] CSR_NUM_CLUSTERS = 2'd1;
   localparam logic [1:0] CSR_WEIGHTED     = 2'd2;

   // cluster table geometry: at most 16 clusters reach the table
   localparam int TBL_SIDE  = 16;
   localparam int TBL_DEPTH = TBL_SIDE * TBL_SIDE;
   localparam int ACC_W     = 48;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_OUT,
      ST_E_LAB,
      ST_MHI,
      ST_MLO,
      ST_COMB,
      ST_E_ACC,
      ST_F_LAB,
      ST_F_GO,
      ST_F_ADD
   } state_type;

endpackage

>>> rtl/cpds_ram.sv
// cpds_ram: generic single write port, single read port ram with registered read
// no dependencies

module cpds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/cpds_mul.sv
// cpds_mul: shared registered multiplier, signed 48-bit times unsigned 16-bit
// no dependencies

module cpds_mul (
   input  logic               clock,
   input  logic signed [47:0] mul_a,
   input  logic        [15:0] mul_b,
   output logic signed [63:0] mul_p
);

   logic signed [16:0] b_s;
   logic signed [64:0] prod;
   logic signed [63:0] mul_p_ff;

   assign b_s  = signed'({1'b0, mul_b});
   assign prod = 65'(mul_a * b_s);

   always_ff @(posedge clock) begin
      mul_p_ff <= prod[63:0];
   end

   assign mul_p = mul_p_ff;

endmodule

>>> rtl/cluster_partial_dissimilarity_sums.sv
// cluster_partial_dissimilarity_sums: top level with sequencer, row accumulators and table
// depends on cpds_pkg, cpds_ram, cpds_mul

// Per-cluster row sums of a dissimilarity matrix streamed in row-major order, folded into a
// 16 x 16 cluster block-sum table. Load items fill the label/weight store (no result), clear
// items zero the table, read items give one table entry through the table ram read and the
// output register. A dissimilarity entry goes through acceptance, a store read of the column
// item, two passes through the single 48x16 multiplier (weight high and low halves), a
// combine step and the accumulator update. An entry that closes a row then fetches the row
// item and, for each cluster in use, passes the multiplier twice again, emits one row-sum
// transfer and, if the row item's label is within the cluster count, read-modify-writes
// the table ram; a stalled output holds the flush. The block takes no new item while it
// works on one; a finished result waits in the output register without holding back the
// next input. Products are floored Q16.16, row accumulators saturate at 48 bits and table
// entries at 64 bits. Label and weight store entries that were never loaded read back as
// undefined values.

module cluster_partial_dissimilarity_sums
   import cpds_pkg::*;
#(
   parameter int MAX_ITEMS    = 1024,
   parameter int MAX_CLUSTERS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [10:0]        csr_data,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [9:0]         req_row_index,
   input  logic [9:0]         req_column_index,
   input  logic [3:0]         req_cluster_label,
   input  logic [3:0]         req_cluster_column,
   input  logic signed [31:0] req_diss_value,
   input  logic [31:0]        req_weight_value,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic [9:0]         rsp_out_row,
   output logic [3:0]         rsp_out_cluster,
   output logic signed [63:0] rsp_result_value,
   output logic               rsp_last
);

   localparam int AW    = $clog2(MAX_ITEMS);
   localparam int NW    = ($clog2(MAX_ITEMS + 1) > 11) ? $clog2(MAX_ITEMS + 1) : 11;
   localparam int NCL_I = (MAX_CLUSTERS < TBL_SIDE) ? MAX_CLUSTERS : TBL_SIDE;
   localparam logic [4:0] NCL = 5'(NCL_I);
   localparam logic [NW-1:0] MAXI = NW'(MAX_ITEMS);
   localparam int TAW = $clog2(TBL_DEPTH);

   // configuration registers
   logic [10:0] num_items_ff;
   logic [4:0]  num_clusters_ff;
   logic        weighted_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_items_ff    <= 11'd1;
         num_clusters_ff <= 5'd16;
         weighted_ff     <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_NUM_ITEMS:    num_items_ff    <= csr_data;
            CSR_NUM_CLUSTERS: num_clusters_ff <= csr_data[4:0];
            CSR_WEIGHTED:     weighted_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // effective counts
   logic [NW-1:0] items_ext, items_eff;
   logic [4:0]    nc;

   assign items_ext = NW'(num_items_ff);
   assign items_eff = (items_ext > MAXI) ? MAXI : items_ext;

   always_comb begin
      if (num_clusters_ff == 5'd0) begin
         nc = 5'd1;
      end else if (num_clusters_ff > NCL) begin
         nc = NCL;
      end else begin
         nc = num_clusters_ff;
      end
   end

   // state
   state_type state_ff, state_in;

   logic               accept;
   logic               slot_free;

   // item registers
   logic [9:0]         row_ff;
   logic [9:0]         col_ff;
   logic [3:0]         lab_ff;
   logic [3:0]         ccol_ff;
   logic signed [31:0] diss_ff;
   logic               rd_ok_ff;

   // working registers
   logic               fl_ff, fl_in;       // multiply pass belongs to the row flush
   logic [3:0]         lc_ff;              // column item label or row item label
   logic [31:0]        w_ff;               // column item weight or row item weight
   logic [3:0]         k_ff, k_in;
   logic signed [63:0] hi_ff;
   logic signed [49:0] term_ff;
   logic signed [47:0] v_ff;
   logic signed [63:0] scaled_ff;
   logic [TAW-1:0]     tidx_ff;

   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // range checks at acceptance
   logic [NW-1:0] row_ext, col_ext;
   logic          entry_ok, load_ok;

   assign row_ext  = NW'(req_row_index);
   assign col_ext  = NW'(req_column_index);
   assign entry_ok = (row_ext < items_eff) && (col_ext < items_eff);
   assign load_ok  = (row_ext < MAXI);

   // label and weight store
   logic          st_rd_en;
   logic [AW-1:0] st_rd_addr;
   logic [35:0]   st_rd_data;

   cpds_ram #(
      .WIDTH (36),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept && (req_kind == KIND_LOAD) && load_ok),
      .wr_addr (row_ext[AW-1:0]),
      .wr_data ({req_cluster_label, req_weight_value}),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // block-sum table with valid bits
   logic [TBL_DEPTH-1:0] tvalid_ff;
   logic                 tb_rd_en;
   logic [TAW-1:0]       tb_rd_addr;
   logic [63:0]          tb_rd_data;
   logic                 tb_wr_en;
   logic [63:0]          tb_wr_data;
   logic signed [63:0]   tbl_val;

   cpds_ram #(
      .WIDTH (64),
      .DEPTH (TBL_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tb_wr_en),
      .wr_addr (tidx_ff),
      .wr_data (tb_wr_data),
      .rd_en   (tb_rd_en),
      .rd_addr (tb_rd_addr),
      .rd_data (tb_rd_data)
   );

   assign tbl_val = tvalid_ff[tidx_ff] ? signed'(tb_rd_data) : 64'sd0;

   always_ff @(posedge clock) begin
      if (reset || (accept && (req_kind == KIND_CLEAR))) begin
         tvalid_ff <= '0;
      end else if (tb_wr_en) begin
         tvalid_ff[tidx_ff] <= 1'b1;
      end
   end

   // row accumulators, one read index at a time
   logic signed [ACC_W-1:0] acc_ff [TBL_SIDE];
   logic [3:0]              acc_idx;
   logic signed [ACC_W-1:0] acc_rd;
   logic                    acc_wr;
   logic signed [ACC_W-1:0] acc_wdata;

   assign acc_idx = (state_ff == ST_E_ACC) ? lc_ff : k_ff;
   assign acc_rd  = acc_ff[acc_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TBL_SIDE; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (acc_wr) begin
         acc_ff[acc_idx] <= acc_wdata;
      end
   end

   // shared multiplier
   logic signed [47:0] mul_a;
   logic [15:0]        mul_b;
   logic signed [63:0] mul_p;

   assign mul_a = fl_ff ? v_ff : 48'(diss_ff);
   assign mul_b = (state_ff == ST_MLO) ? w_ff[15:0] : w_ff[31:16];

   cpds_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   // combine hi + floor(lo / 2^16), saturating to 64 bits
   logic signed [63:0] lo_sh;
   logic signed [64:0] comb_sum;
   logic signed [63:0] comb_sat;

   assign lo_sh    = mul_p >>> 16;
   assign comb_sum = 65'(hi_ff) + 65'(lo_sh);
   assign comb_sat = (comb_sum[64] != comb_sum[63])
                   ? (comb_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                   : comb_sum[63:0];

   // accumulator update, saturating to 48 bits; cleared instead in the row flush
   logic signed [49:0] acc_sum;

   assign acc_sum = 50'(acc_rd) + term_ff;

   always_comb begin
      if (state_ff == ST_F_ADD) begin
         acc_wdata = '0;
      end else if (acc_sum[49:47] == 3'b000 || acc_sum[49:47] == 3'b111) begin
         acc_wdata = acc_sum[47:0];
      end else if (acc_sum[49]) begin
         acc_wdata = {1'b1, 47'd0};
      end else begin
         acc_wdata = {1'b0, {47{1'b1}}};
      end
   end

   // table update, saturating to 64 bits
   logic signed [64:0] tb_sum;

   assign tb_sum     = 65'(tbl_val) + 65'(scaled_ff);
   assign tb_wr_data = (tb_sum[64] != tb_sum[63])
                     ? (tb_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                     : tb_sum[63:0];

   // response register
   logic               rsp_load;
   logic               rsp_kind_in;
   logic [9:0]         rsp_row_in;
   logic [3:0]         rsp_cl_in;
   logic signed [63:0] rsp_val_in;
   logic               rsp_last_in;
   logic               rsp_valid_ff;
   logic               rsp_kind_ff;
   logic [9:0]         rsp_row_ff;
   logic [3:0]         rsp_cl_ff;
   logic signed [63:0] rsp_val_ff;
   logic               rsp_last_ff;

   logic last_col;
   logic k_last;
   logic rl_in_range;

   assign last_col    = (NW'(col_ff) == (items_eff - NW'(1)));
   assign k_last      = ({1'b0, k_ff} == (nc - 5'd1));
   assign rl_in_range = ({1'b0, lc_ff} < nc);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      fl_in       = fl_ff;
      k_in        = k_ff;
      st_rd_en    = 1'b0;
      st_rd_addr  = col_ext[AW-1:0];
      tb_rd_en    = 1'b0;
      tb_rd_addr  = {req_cluster_label, req_cluster_column};
      tb_wr_en    = 1'b0;
      acc_wr      = 1'b0;
      rsp_load    = 1'b0;
      rsp_kind_in = RES_ROW_SUM;
      rsp_row_in  = row_ff;
      rsp_cl_in   = k_ff;
      rsp_val_in  = 64'(v_ff);
      rsp_last_in = k_last;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_READ: begin
                     tb_rd_en = 1'b1;
                     state_in = ST_RD_OUT;
                  end
                  KIND_ENTRY: begin
                     if (entry_ok) begin
                        st_rd_en = 1'b1;
                        fl_in    = 1'b0;
                        state_in = ST_E_LAB;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RD_OUT: begin
            if (slot_free) begin
               rsp_load    = 1'b1;
               rsp_kind_in = RES_READ;
               rsp_row_in  = 10'(lab_ff);
               rsp_cl_in   = ccol_ff;
               rsp_val_in  = rd_ok_ff ? tbl_val : 64'sd0;
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_E_LAB: begin
            state_in = ST_MHI;
         end
         ST_MHI: begin
            state_in = ST_MLO;
         end
         ST_MLO: begin
            tb_rd_en   = fl_ff;
            tb_rd_addr = {lc_ff, k_ff};
            state_in   = ST_COMB;
         end
         ST_COMB: begin
            state_in = fl_ff ? ST_F_ADD : ST_E_ACC;
         end
         ST_E_ACC: begin
            acc_wr = rl_in_range;
            if (last_col) begin
               st_rd_en   = 1'b1;
               st_rd_addr = NW'(row_ff) >= MAXI ? '0 : AW'(row_ff);
               state_in   = ST_F_LAB;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_F_LAB: begin
            k_in     = 4'd0;
            fl_in    = 1'b1;
            state_in = ST_F_GO;
         end
         ST_F_GO: begin
            state_in = ST_MHI;
         end
         ST_F_ADD: begin
            if (slot_free) begin
               rsp_load  = 1'b1;
               tb_wr_en  = rl_in_range;
               acc_wr    = 1'b1;
               if (k_last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 4'd1;
                  state_in = ST_F_GO;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fl_ff    <= 1'b0;
         k_ff     <= 4'd0;
      end else begin
         state_ff <= state_in;
         fl_ff    <= fl_in;
         k_ff     <= k_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff   <= req_row_index;
         col_ff   <= req_column_index;
         lab_ff   <= req_cluster_label;
         ccol_ff  <= req_cluster_column;
         diss_ff  <= req_diss_value;
         rd_ok_ff <= ({1'b0, req_cluster_label} < NCL) && ({1'b0, req_cluster_column} < NCL);
         tidx_ff  <= {req_cluster_label, req_cluster_column};
      end
      if (state_ff == ST_E_LAB || state_ff == ST_F_LAB) begin
         lc_ff <= st_rd_data[35:32];
         w_ff  <= st_rd_data[31:0];
      end
      if (state_ff == ST_MLO) begin
         hi_ff <= mul_p;
      end
      if (state_ff == ST_MLO && fl_ff) begin
         tidx_ff <= {lc_ff, k_ff};
      end
      if (state_ff == ST_F_GO) begin
         v_ff <= acc_rd;
      end
      if (state_ff == ST_COMB) begin
         term_ff   <= weighted_ff ? comb_sat[49:0] : 50'(diss_ff);
         scaled_ff <= weighted_ff ? comb_sat : 64'(v_ff);
      end
   end

   // with a row flush the accumulator slot is cleared once it is emitted
   // (acc_wdata is only the saturated sum in the entry path)

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_row_ff  <= rsp_row_in;
         rsp_cl_ff   <= rsp_cl_in;
         rsp_val_ff  <= rsp_val_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_out_row      = rsp_row_ff;
   assign rsp_out_cluster  = rsp_cl_ff;
   assign rsp_result_value = rsp_val_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

>>> rtl/cpds_checker.sv
// cpds_checker: port-level assertions for the cluster partial dissimilarity sums block
// depends on cpds_pkg; bound to cluster_partial_dissimilarity_sums

module cpds_checker
   import cpds_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [1:0]         req_kind,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_result_kind,
   input logic signed [63:0] rsp_result_value,
   input logic               rsp_last
);

   // no result survives a reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value))
      else $error("stalled result changed");

   // a table read is always a single transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == RES_READ) |-> rsp_last)
      else $error("read result without last");

   // a read keeps the block busy for at least the table access
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind == KIND_READ) |=> req_stall)
      else $error("read accepted without busy cycle");

endmodule

bind cluster_partial_dissimilarity_sums cpds_checker u_cpds_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_kind         (req_kind),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_kind  (rsp_result_kind),
   .rsp_result_value (rsp_result_value),
   .rsp_last         (rsp_last)
);

>>> test/cluster_partial_dissimilarity_sums_test.sv
// cluster_partial_dissimilarity_sums_test: self-checking bench for the cluster block-sum engine
// depends on cpds_pkg and cluster_partial_dissimilarity_sums; directed tasks then random phases
`timescale 1ns / 100ps

module cluster_partial_dissimilarity_sums_test;
   import cpds_pkg::*;

   // one row-sum or table-read transfer as it should appear on the response side
   typedef struct {
      logic               kind;
      logic [9:0]         row;
      logic [3:0]         cl;
      logic signed [63:0] val;
      logic               last;
   } sum_rec_type;

   localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint ACC_LO = -ACC_HI - 1;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write = 1'b0;
   logic [1:0]         csr_index = CSR_NUM_ITEMS;
   logic [10:0]        csr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_kind = KIND_LOAD;
   logic [9:0]         req_row_index = '0;
   logic [9:0]         req_column_index = '0;
   logic [3:0]         req_cluster_label = '0;
   logic [3:0]         req_cluster_column = '0;
   logic signed [31:0] req_diss_value = '0;
   logic [31:0]        req_weight_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_result_kind;
   logic [9:0]         rsp_out_row;
   logic [3:0]         rsp_out_cluster;
   logic signed [63:0] rsp_result_value;
   logic               rsp_last;

   cluster_partial_dissimilarity_sums dut (.*);

   // predictor state: registers, label/weight store, row accumulators, block table
   int unsigned   cfg_items = 1;
   int unsigned   cfg_clusters = 16;
   bit            cfg_weighted = 1'b0;
   logic [3:0]    label_mem [1024];
   logic [31:0]   weight_mem [1024];
   longint        row_acc [16];
   longint        block_tbl [16][16];
   sum_rec_type   pending_sums [$];
   int            error_count = 0;
   bit            calm = 1'b0;   // no idling on either side

   initial forever #4 clock = ~clock;

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // saturate a 65-bit sum into the signed 64-bit range
   function automatic longint clip64(logic signed [64:0] x);
      if (x[64] != x[63]) return x[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      return x[63:0];
   endfunction

   function automatic longint add_sat64(longint a, longint b);
      logic signed [64:0] ea, eb;
      ea = a;
      eb = b;
      return clip64(ea + eb);
   endfunction

   // row sum times unsigned Q16.16 weight, split in halves as the block does, floored
   function automatic longint weigh_row_sum(longint acc, logic [31:0] w);
      longint hi, lo, wh, wl;
      wh = {48'd0, w[31:16]};
      wl = {48'd0, w[15:0]};
      hi = acc * wh;
      lo = (acc * wl) >>> 16;
      return add_sat64(hi, lo);
   endfunction

   // work out what one accepted transfer produces and queue it
   task automatic predict_sums(logic [1:0] kind, logic [9:0] row, logic [9:0] col,
                               logic [3:0] lab, logic [3:0] ccol,
                               logic signed [31:0] diss, logic [31:0] wt);
      int unsigned items, nc, k;
      longint term, v, w64;
      logic [3:0] rl;
      sum_rec_type rec;
      items = (cfg_items > 1024) ? 1024 : cfg_items;
      nc = (cfg_clusters < 1) ? 1 : (cfg_clusters > 16 ? 16 : cfg_clusters);
      case (kind)
         KIND_LOAD: begin
            label_mem[row] = lab;
            weight_mem[row] = wt;
         end
         KIND_CLEAR: begin
            foreach (block_tbl[i, j]) block_tbl[i][j] = 0;
         end
         KIND_READ: begin
            rec = '{RES_READ, {6'd0, lab}, ccol, block_tbl[lab][ccol], 1'b1};
            pending_sums.push_back(rec);
         end
         default: begin
            if (row >= items || col >= items) return;
            k = label_mem[col];
            if (k < nc) begin
               w64 = {32'd0, weight_mem[col]};
               term = diss;
               if (cfg_weighted) term = (term * w64) >>> 16;
               v = row_acc[k] + term;
               row_acc[k] = (v > ACC_HI) ? ACC_HI : ((v < ACC_LO) ? ACC_LO : v);
            end
            if (col != items - 1) return;
            // end of row: one transfer per cluster, fold into the row item's table row
            rl = label_mem[row];
            for (k = 0; k < nc; k++) begin
               v = row_acc[k];
               rec = '{RES_ROW_SUM, row, k[3:0], v, k == nc - 1};
               pending_sums.push_back(rec);
               if (rl < nc) begin
                  if (cfg_weighted) v = weigh_row_sum(v, weight_mem[row]);
                  block_tbl[rl][k] = add_sat64(block_tbl[rl][k], v);
               end
               row_acc[k] = 0;
            end
         end
      endcase
   endtask

   // response checker: compare every accepted transfer with the oldest expectation
   always @(posedge clock) begin
      sum_rec_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sums.size() == 0) begin
            $display("%t unexpected transfer: kind %0d row %0d cluster %0d value %0d", $time,
                     rsp_result_kind, rsp_out_row, rsp_out_cluster, rsp_result_value);
            error_count++;
         end else begin
            e = pending_sums.pop_front();
            if (rsp_result_kind !== e.kind) begin
               $display("%t result_kind expected %0d actual %0d", $time, e.kind, rsp_result_kind);
               error_count++;
            end
            if (rsp_out_row !== e.row) begin
               $display("%t out_row expected %0d actual %0d", $time, e.row, rsp_out_row);
               error_count++;
            end
            if (rsp_out_cluster !== e.cl) begin
               $display("%t out_cluster expected %0d actual %0d", $time, e.cl, rsp_out_cluster);
               error_count++;
            end
            if (rsp_result_value !== e.val) begin
               $display("%t result_value expected %0d actual %0d", $time, e.val,
                        rsp_result_value);
               error_count++;
            end
            if (rsp_last !== e.last) begin
               $display("%t last expected %0d actual %0d", $time, e.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // receiver stalls in random bursts
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            rsp_stall = 1'b0;
            if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 6);
         end
      end
   end

   // one request transfer, then maybe a random gap with the request withdrawn
   task automatic send_item(logic [1:0] kind, logic [9:0] row, logic [9:0] col,
                            logic [3:0] lab, logic [3:0] ccol,
                            logic [31:0] diss, logic [31:0] wt);
      int gap;
      @(negedge clock);
      req_valid = 1'b1;
      req_kind = kind;
      req_row_index = row;
      req_column_index = col;
      req_cluster_label = lab;
      req_cluster_column = ccol;
      req_diss_value = diss;
      req_weight_value = wt;
      do @(posedge clock); while (req_stall);
      predict_sums(kind, row, col, lab, ccol, diss, wt);
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic load_item(int idx, int unsigned lab, logic [31:0] wt);
      send_item(KIND_LOAD, 10'(idx), 10'($urandom), 4'(lab), 4'($urandom), $urandom, wt);
   endtask

   task automatic send_entry(int row, int col, logic [31:0] diss);
      send_item(KIND_ENTRY, 10'(row), 10'(col), 4'($urandom), 4'($urandom), diss, $urandom);
   endtask

   task automatic read_cell(int unsigned r, int unsigned c);
      send_item(KIND_READ, 10'($urandom), 10'($urandom), 4'(r), 4'(c), $urandom, $urandom);
   endtask

   task automatic clear_table();
      send_item(KIND_CLEAR, 10'($urandom), 10'($urandom), 4'($urandom), 4'($urandom),
                $urandom, $urandom);
   endtask

   // sender holds off until every expected transfer has come, plus the entry latency
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   // register writes only while drained
   task automatic write_csr(logic [1:0] idx, int unsigned value);
      drain();
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value[10:0];
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         CSR_NUM_ITEMS:    cfg_items = value & 11'h7FF;
         CSR_NUM_CLUSTERS: cfg_clusters = value & 5'h1F;
         default:          cfg_weighted = value[0];
      endcase
   endtask

   // unweighted rows, labels beyond the cluster count, extreme entries, reads and clear
   task automatic test_plain_rows();
      write_csr(CSR_NUM_ITEMS, 4);
      write_csr(CSR_NUM_CLUSTERS, 3);
      write_csr(CSR_WEIGHTED, 0);
      load_item(0, 0, 32'h0001_0000);
      load_item(1, 2, 32'h0002_0000);
      load_item(2, 15, 32'hFFFF_FFFF);
      load_item(3, 1, 32'h0000_0000);
      load_item(1023, 15, 32'hFFFF_FFFF);
      send_entry(0, 0, 32'h7FFF_FFFF);
      send_entry(0, 1, 32'h8000_0000);
      send_entry(0, 2, 32'h1234_5678);
      send_entry(0, 3, 32'hFFFF_FFFF);
      send_entry(2, 3, 32'h0001_0000);   // row whose item label is out of range
      read_cell(0, 0);
      read_cell(0, 2);
      read_cell(15, 15);
      clear_table();
      read_cell(0, 0);
   endtask

   // weighted mode with zero and maximal weights, accumulator and table saturation
   task automatic test_weighted_saturation();
      write_csr(CSR_WEIGHTED, 1);
      write_csr(CSR_NUM_ITEMS, 2);
      write_csr(CSR_NUM_CLUSTERS, 0);    // zero clusters behaves as one
      load_item(0, 0, 32'hFFFF_FFFF);
      load_item(1, 0, 32'h0000_0000);
      send_entry(0, 0, 32'h7FFF_FFFF);
      send_entry(0, 1, 32'h7FFF_FFFF);
      send_entry(1, 0, 32'h8000_0000);
      send_entry(1, 1, 32'h8000_0000);
      send_entry(0, 0, 32'h8000_0000);
      send_entry(0, 1, 32'h0000_0001);
      read_cell(0, 0);
      send_entry(1023, 1, 32'h0001_0000); // row beyond the item count is ignored
      send_entry(0, 1023, 32'h0001_0000); // column beyond the item count is ignored
      write_csr(CSR_NUM_CLUSTERS, 31);
      read_cell(0, 0);
   endtask

   // item count at its extremes: clipped to the store size, and one item per row
   task automatic test_item_count_extremes();
      write_csr(CSR_NUM_ITEMS, 2047);
      load_item(600, 9, 32'h0003_8000);
      send_entry(1023, 600, 32'hFFF0_0000);
      send_entry(600, 1023, 32'h0010_0000);
      read_cell(15, 0);
      write_csr(CSR_NUM_ITEMS, 1);
      write_csr(CSR_WEIGHTED, 0);
      send_entry(0, 0, 32'h0000_8000);
      read_cell(0, 0);
   endtask

   // random phases: load every item, then rows in order with random content and noise
   task automatic test_random_phases();
      int unsigned items, row, col, pick, ops;
      for (int p = 0; p < 6; p++) begin
         calm = (p == 5);
         items = (p == 2) ? 20 : $urandom_range(1, 8);
         write_csr(CSR_NUM_ITEMS, items);
         write_csr(CSR_NUM_CLUSTERS, (p == 3) ? 16 : $urandom_range(0, 31));
         write_csr(CSR_WEIGHTED, $urandom_range(0, 1));
         load_item(1023, $urandom, $urandom);
         for (int i = 0; i < items; i++)
            load_item(i, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4),
                      $urandom_range(0, 1) ? $urandom : $urandom_range(32'h8000, 32'h3_0000));
         row = 0;
         col = 0;
         ops = (p == 2) ? 60 : 15;
         for (int n = 0; n < ops; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
               send_entry(row, col, $urandom_range(0, 1) ? $urandom
                                                         : $urandom_range(0, 32'h4_0000) - 32'h2_0000);
               col++;
               if (col == items) begin
                  col = 0;
                  row = (row + 1) % items;
               end
            end else if (pick < 16) begin
               read_cell($urandom, $urandom);
            end else if (pick == 16) begin
               if ($urandom_range(0, 2) == 0) clear_table();
            end else if (pick == 17) begin
               load_item($urandom_range(0, 1023), $urandom, $urandom);
            end else if (pick == 18) begin
               send_entry($urandom_range(0, items - 1), 1023, $urandom);
            end else if ($urandom_range(0, 3) == 0) begin
               drain();
            end
         end
         for (int r = 0; r < 4; r++) read_cell($urandom_range(0, 4), $urandom_range(0, 4));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_plain_rows();
      test_weighted_saturation();
      test_item_count_extremes();
      test_random_phases();
      drain();
      repeat (40) @(posedge clock);
      if (error_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
